>>> rtl/core/kfq_pkg.sv
// Types and command codes shared by the keyed queue cells and the core.
// No dependencies.
package kfq_pkg;
	typedef enum logic [2:0] {
		CMD_PUSH     = 3'd0,
		CMD_POP      = 3'd1,
		CMD_CANCEL   = 3'd2,
		CMD_CANCEL_N = 3'd3,
		CMD_SEARCH   = 3'd4,
		CMD_SORT_UP  = 3'd5,
		CMD_SORT_DN  = 3'd6,
		CMD_NOP      = 3'd7
	} cmd_t;

	typedef struct packed {
		logic [63:0] name;
		logic [20:0] tm;
	} rec_t;

	localparam logic [63:0] NULL_NAME = 64'd97;
	localparam int KEY_W = 20;
endpackage

>>> rtl/core/kfq_cell.sv
// One queue slot: holds a record and compares it to the operand.
// Depends on kfq_pkg.
module kfq_cell (
	input  logic          clk,
	input  logic          load,
	input  kfq_pkg::rec_t d,
	input  kfq_pkg::rec_t op,
	input  logic          use_name,
	output kfq_pkg::rec_t q,
	output logic          hit
);
	import kfq_pkg::*;
	rec_t rec_q;

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= d;
		end
	end

	assign q   = rec_q;
	assign hit = (rec_q.tm == op.tm) && (!use_name || rec_q.name == op.name);
endmodule

>>> rtl/core/keyed_fifo_with_cancel_and_sort_core.sv
// Top level of the keyed queue: command decode, cell row and result register.
// Depends on kfq_pkg and kfq_cell.
//
// Use: commands enter on s_axis (tdata: cmd, name_tag, kind, day, month, hour,
// minute). Results leave on m_axis (tdata: ok, out_name, out_kind, out_day,
// out_month, out_hour, out_minute, is_empty), tlast on the final beat.
// Push, pop, cancel, search and nop give one beat each, loaded into the
// output register from the EXEC state after the command is taken; a new
// command is taken only when the previous one is done and the output is
// free. Sorts give one beat per stored record (one beat with ok low on an
// empty queue); each beat is chosen by a linear scan over the row, one cell
// per cycle, and the OUT state then loads the beat. Cancel and pop shift
// the row toward the head.
// Reset empties the queue (count zero) and the output register.
// A stall on m_axis holds the beat and the next command waits.
module keyed_fifo_with_cancel_and_sort_core #(
	parameter int DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,  // cmd, name_tag, kind, day, month, hour, minute
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [87:0]  m_axis_tdata,  // ok, out_name, out_kind, out_day, out_month,
	                                    // out_hour, out_minute, is_empty
	output logic         m_axis_tlast
);
	import kfq_pkg::*;
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t       state_q;
	cmd_t         cmd_q;
	rec_t         op_q;
	logic [CW-1:0] cnt_q;
	rec_t         row [DEPTH];
	rec_t         nxt [DEPTH];
	logic [DEPTH-1:0] load, hit, taken_q;
	logic [IW-1:0] scan_q, best_q, rm_idx;
	logic         best_v_q;
	logic [CW-1:0] emit_q;
	logic         found;

	// output register
	logic         ov_q, olast_q, ook_q;
	rec_t         orec_q;
	logic         oempty_q;

	// single-beat command result
	logic         ex_ok, ex_empty, ex_sort;
	rec_t         ex_rec;
	logic [CW-1:0] ex_cnt;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		kfq_cell u_cell (
			.clk      (clk),
			.load     (load[g]),
			.d        (nxt[g]),
			.op       (op_q),
			.use_name (cmd_q == CMD_CANCEL),
			.q        (row[g]),
			.hit      (hit[g])
		);
	end

	// first live hit
	always_comb begin
		found  = 1'b0;
		rm_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hit[i] && (CW'(i) < cnt_q)) begin
				found  = 1'b1;
				rm_idx = IW'(i);
			end
		end
	end

	wire do_exec = (state_q == ST_EXEC) && !ov_q;
	wire is_rm   = (cmd_q == CMD_POP && cnt_q != '0) ||
		((cmd_q == CMD_CANCEL || cmd_q == CMD_CANCEL_N) && found);
	wire [IW-1:0] rm_at = (cmd_q == CMD_POP) ? '0 : rm_idx;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			load[i] = 1'b0;
			nxt[i]  = op_q;
			if (do_exec) begin
				if (cmd_q == CMD_PUSH && CW'(i) == cnt_q) begin
					load[i] = 1'b1;
				end else if (is_rm && IW'(i) >= rm_at && i < DEPTH - 1) begin
					load[i] = 1'b1;
					nxt[i]  = row[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_comb begin
		ex_ok    = 1'b0;
		ex_rec   = '0;
		ex_empty = (cnt_q == '0);
		ex_sort  = 1'b0;
		ex_cnt   = cnt_q;
		unique case (cmd_q)
			CMD_PUSH: begin
				if (cnt_q != CW'(DEPTH)) begin
					ex_cnt   = cnt_q + 1'b1;
					ex_ok    = 1'b1;
					ex_empty = 1'b0;
				end
			end
			CMD_POP, CMD_CANCEL, CMD_CANCEL_N: begin
				if (is_rm) begin
					ex_cnt   = cnt_q - 1'b1;
					ex_ok    = 1'b1;
					ex_rec   = row[rm_at];
					ex_empty = (cnt_q == CW'(1));
				end
			end
			CMD_SEARCH: begin
				ex_ok  = found;
				ex_rec = found ? row[rm_idx] : rec_t'({NULL_NAME, 21'd0});
			end
			CMD_SORT_UP, CMD_SORT_DN: begin
				ex_sort = (cnt_q != '0);
			end
			default: begin
			end
		endcase
	end

	wire [KEY_W-1:0] k_scan = row[scan_q].tm[KEY_W-1:0];
	wire [KEY_W-1:0] k_best = row[best_q].tm[KEY_W-1:0];
	wire better = !best_v_q || ((cmd_q == CMD_SORT_UP) ? (k_scan < k_best) : (k_scan > k_best));

	assign s_axis_tready = (state_q == ST_IDLE) && !ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ov_q     <= 1'b0;
			olast_q  <= 1'b0;
			ook_q    <= 1'b0;
			orec_q   <= '0;
			oempty_q <= 1'b0;
			op_q     <= '0;
			taken_q  <= '0;
			scan_q   <= '0;
			best_q   <= '0;
			best_v_q <= 1'b0;
			emit_q   <= '0;
			cmd_q    <= CMD_NOP;
		end else begin
			if (ov_q && m_axis_tready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						cmd_q      <= cmd_t'(s_axis_tdata[2:0]);
						op_q.name  <= s_axis_tdata[66:3];
						op_q.tm    <= {s_axis_tdata[67], s_axis_tdata[76:73],
							s_axis_tdata[72:68], s_axis_tdata[81:77], s_axis_tdata[87:82]};
						state_q    <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (!ov_q) begin
						cnt_q <= ex_cnt;
						if (ex_sort) begin
							taken_q  <= '0;
							scan_q   <= '0;
							best_v_q <= 1'b0;
							emit_q   <= '0;
							state_q  <= ST_SCAN;
						end else begin
							ov_q     <= 1'b1;
							olast_q  <= 1'b1;
							ook_q    <= ex_ok;
							orec_q   <= ex_rec;
							oempty_q <= ex_empty;
							state_q  <= ST_IDLE;
						end
					end
				end
				ST_SCAN: begin
					if (!taken_q[scan_q] && better) begin
						best_q   <= scan_q;
						best_v_q <= 1'b1;
					end
					if (CW'(scan_q) == cnt_q - 1'b1) begin
						state_q <= ST_OUT;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (!ov_q) begin
						ov_q             <= 1'b1;
						ook_q            <= 1'b1;
						orec_q           <= row[best_q];
						oempty_q         <= 1'b0;
						olast_q          <= (emit_q == cnt_q - 1'b1);
						taken_q[best_q]  <= 1'b1;
						emit_q           <= emit_q + 1'b1;
						scan_q           <= '0;
						best_v_q         <= 1'b0;
						state_q          <= (emit_q == cnt_q - 1'b1) ? ST_IDLE : ST_SCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tlast  = olast_q;
	assign m_axis_tdata  = {1'b0, oempty_q, orec_q.tm[5:0], orec_q.tm[10:6],
		orec_q.tm[19:16], orec_q.tm[15:11], orec_q.tm[20], orec_q.name, ook_q};

	logic unused_in;
	assign unused_in = ^s_axis_tdata[95:88];
endmodule

>>> bench/keyed_fifo_with_cancel_and_sort_core_tb.sv
// Testbench for the keyed queue core: drives commands on s_axis, predicts every
// result beat (push, pop, cancel, search, sorts) and checks m_axis beats in order.
// Depends on kfq_pkg and keyed_fifo_with_cancel_and_sort_core.
module keyed_fifo_with_cancel_and_sort_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kfq_pkg::*;

	typedef struct packed {
		logic        ok;
		logic [63:0] name;
		logic [20:0] tm;
		logic        empty;
		logic        last;
	} beat_t;

	class queue_scoreboard;
		logic [63:0] names[$];
		logic [20:0] times[$];
		beat_t       pending[$];
		int          errors;
		int          depth;

		function new(int d);
			depth = d;
			errors = 0;
		endfunction

		function void add(logic ok, logic [63:0] nm, logic [20:0] tm, logic lst);
			beat_t b;
			b.ok = ok; b.name = nm; b.tm = tm;
			b.empty = (names.size() == 0); b.last = lst;
			pending.push_back(b);
		endfunction

		function void note_command(cmd_t cmd, logic [63:0] nm, logic [20:0] tm);
			int    hit;
			int    best;
			bit    taken[$];
			logic [63:0] hn;
			logic [20:0] ht;
			hit = -1;
			case (cmd)
				CMD_PUSH: begin
					if (names.size() < depth) begin
						names.push_back(nm); times.push_back(tm); add(1, 0, 0, 1);
					end else add(0, 0, 0, 1);
				end
				CMD_POP: begin
					if (names.size() > 0) begin
						hn = names.pop_front(); ht = times.pop_front(); add(1, hn, ht, 1);
					end else add(0, 0, 0, 1);
				end
				CMD_CANCEL, CMD_CANCEL_N: begin
					foreach (names[i])
						if (hit < 0 && times[i] == tm && (cmd == CMD_CANCEL_N || names[i] == nm))
							hit = i;
					if (hit >= 0) begin
						hn = names[hit]; ht = times[hit];
						names.delete(hit); times.delete(hit);
						add(1, hn, ht, 1);
					end else add(0, 0, 0, 1);
				end
				CMD_SEARCH: begin
					foreach (names[i])
						if (hit < 0 && times[i] == tm) hit = i;
					if (hit >= 0) add(1, names[hit], times[hit], 1);
					else add(0, NULL_NAME, 0, 1);
				end
				CMD_SORT_UP, CMD_SORT_DN: begin
					if (names.size() == 0) add(0, 0, 0, 1);
					else begin
						foreach (names[i]) taken.push_back(0);
						for (int k = 0; k < names.size(); k++) begin
							best = -1;
							foreach (names[i]) begin
								if (taken[i]) continue;
								if (best < 0) best = i;
								else if (cmd == CMD_SORT_UP ?
									times[i][KEY_W-1:0] < times[best][KEY_W-1:0] :
									times[i][KEY_W-1:0] > times[best][KEY_W-1:0])
									best = i;
							end
							taken[best] = 1;
							add(1, names[best], times[best], k == names.size() - 1);
						end
					end
				end
				default: add(0, 0, 0, 1);
			endcase
		endfunction

		function void check_beat(beat_t got);
			beat_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: mismatch expected ok=%b name=%h tm=%h empty=%b last=%b",
					$time, want.ok, want.name, want.tm, want.empty, want.last);
				$display("%0t:          actual   ok=%b name=%h tm=%h empty=%b last=%b",
					$time, got.ok, got.name, got.tm, got.empty, got.last);
				errors++;
			end
		endfunction
	endclass

	localparam int DEPTH = 16;
	localparam int WATCHDOG = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [87:0] m_axis_tdata;
	logic        m_axis_tlast;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int idle_cycles = 0;
	logic [63:0] names_used[$];
	logic [20:0] times_used[$];
	queue_scoreboard sb;

	keyed_fifo_with_cancel_and_sort_core #(.DEPTH(DEPTH)) u_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_beat({m_axis_tdata[0], m_axis_tdata[64:1], m_axis_tdata[65],
					m_axis_tdata[74:71], m_axis_tdata[70:66], m_axis_tdata[79:75],
					m_axis_tdata[85:80], m_axis_tdata[86], m_axis_tlast});
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG) begin
				$display("keyed_fifo_with_cancel_and_sort_core_tb: done, errors");
				$finish;
			end
		end
	end

	task automatic send(cmd_t cmd, logic [63:0] nm, logic [20:0] tm);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		// zero pad, then minute, hour, month, day, kind, name, cmd from bit 95 down
		s_axis_tdata <= {8'b0, tm[5:0], tm[10:6], tm[19:16], tm[15:11], tm[20], nm, cmd};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_command(cmd, nm, tm);
		if (cmd == CMD_PUSH) begin
			names_used.push_back(nm); times_used.push_back(tm);
		end
	endtask

	function automatic logic [20:0] rand_time();
		return {1'($urandom), 4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
			5'($urandom_range(0, 23)), 6'($urandom_range(0, 59))};
	endfunction

	function automatic logic [63:0] rand_name();
		return {$urandom, $urandom} >> (8 * $urandom_range(0, 7));
	endfunction

	task automatic random_command();
		int          r;
		int          j;
		logic [63:0] nm;
		logic [20:0] tm;
		r = $urandom_range(99);
		nm = rand_name();
		tm = $urandom_range(3) == 0 ? 21'($urandom) : rand_time();
		if (names_used.size() > 0 && $urandom_range(99) < 60) begin
			j = $urandom_range(names_used.size() - 1);
			tm = times_used[j];
			if ($urandom_range(3) != 0) nm = names_used[j];
		end
		if (r < 38) send(CMD_PUSH, nm, tm);
		else if (r < 50) send(CMD_POP, nm, tm);
		else if (r < 64) send(CMD_CANCEL, nm, tm);
		else if (r < 76) send(CMD_CANCEL_N, nm, tm);
		else if (r < 88) send(CMD_SEARCH, nm, tm);
		else if (r < 93) send(CMD_SORT_UP, nm, tm);
		else if (r < 98) send(CMD_SORT_DN, nm, tm);
		else send(CMD_NOP, nm, tm);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() > 0) @(posedge clk);
	endtask

	initial begin
		sb = new(DEPTH);
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(CMD_POP, 0, 0);
		send(CMD_SORT_UP, 0, 0);
		send(CMD_SEARCH, 0, 0);
		send(CMD_CANCEL, 0, 0);
		send(CMD_PUSH, '1, '1);
		send(CMD_PUSH, 64'h0000_0000_0041_0042, {1'b0, 4'd12, 5'd31, 5'd23, 6'd59});
		send(CMD_PUSH, 64'h4100_0000_0000_0000, {1'b1, 4'd1, 5'd1, 5'd0, 6'd0});
		send(CMD_PUSH, 64'h1, {1'b0, 4'd1, 5'd1, 5'd0, 6'd0});
		send(CMD_PUSH, 64'h2, {1'b1, 4'd12, 5'd31, 5'd23, 6'd59});
		send(CMD_SORT_UP, 0, 0);
		send(CMD_SORT_DN, 0, 0);
		send(CMD_SEARCH, 0, {1'b0, 4'd1, 5'd1, 5'd0, 6'd0});
		send(CMD_SEARCH, 0, {1'b0, 4'd2, 5'd1, 5'd0, 6'd0});
		send(CMD_CANCEL, 64'h2, {1'b0, 4'd1, 5'd1, 5'd0, 6'd0});
		send(CMD_CANCEL_N, 64'h2, {1'b0, 4'd1, 5'd1, 5'd0, 6'd0});
		send(CMD_CANCEL, 64'h2, {1'b1, 4'd12, 5'd31, 5'd23, 6'd59});
		send(CMD_NOP, '1, '1);
		for (int i = 0; i < DEPTH; i++) send(CMD_PUSH, 64'(i), 21'(i * 977));
		send(CMD_SORT_DN, 0, 0);
		send(CMD_POP, 0, 0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = ph == 1 ? 63 : ph == 3 ? 23 : 0;
			recv_stall_pct = ph == 2 ? 63 : ph == 3 ? 23 : 0;
			for (int i = 0; i < 60; i++) random_command();
			drain();
		end
		recv_stall_pct = 0;
		repeat (400) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("keyed_fifo_with_cancel_and_sort_core_tb: done, clean");
		else
			$display("keyed_fifo_with_cancel_and_sort_core_tb: done, errors");
		$finish;
	end
endmodule

>>> files.f
rtl/core/kfq_pkg.sv
rtl/core/kfq_cell.sv
rtl/core/keyed_fifo_with_cancel_and_sort_core.sv
bench/keyed_fifo_with_cancel_and_sort_core_tb.sv
